### src/bbsp_pkg.sv
`timescale 1ns / 1ps
package bbsp_pkg;

  // Field class codes carried on each result
  localparam logic [4:0] FC_HEADER   = 5'd0;
  localparam logic [4:0] FC_TXCOUNT  = 5'd1;
  localparam logic [4:0] FC_VERSION  = 5'd2;
  localparam logic [4:0] FC_MARKER   = 5'd3;
  localparam logic [4:0] FC_INCOUNT  = 5'd4;
  localparam logic [4:0] FC_OUTPOINT = 5'd5;
  localparam logic [4:0] FC_SIGLEN   = 5'd6;
  localparam logic [4:0] FC_SIG      = 5'd7;
  localparam logic [4:0] FC_SEQUENCE = 5'd8;
  localparam logic [4:0] FC_OUTCOUNT = 5'd9;
  localparam logic [4:0] FC_VALUE    = 5'd10;
  localparam logic [4:0] FC_SPKLEN   = 5'd11;
  localparam logic [4:0] FC_SPK      = 5'd12;
  localparam logic [4:0] FC_WITCOUNT = 5'd13;
  localparam logic [4:0] FC_ITEMLEN  = 5'd14;
  localparam logic [4:0] FC_ITEM     = 5'd15;
  localparam logic [4:0] FC_LOCKTIME = 5'd16;

  // Status codes
  localparam logic [3:0] ST_BUSY        = 4'd0;
  localparam logic [3:0] ST_OK          = 4'd1;
  localparam logic [3:0] ST_TRUNCATED   = 4'd2;
  localparam logic [3:0] ST_BAD_FLAG    = 4'd3;
  localparam logic [3:0] ST_ZERO_INPUTS = 4'd4;
  localparam logic [3:0] ST_TRAILING    = 4'd5;
  localparam logic [3:0] ST_NO_TX       = 4'd6;
  localparam logic [3:0] ST_NOT_CB      = 4'd7;
  localparam logic [3:0] ST_NO_COMMIT   = 4'd8;
  localparam logic [3:0] ST_BAD_CB_WIT  = 4'd9;
  localparam logic [3:0] ST_HELD        = 4'd10;

  localparam logic [33:0] W34_MAX = 34'h3FFFFFFFF;
  localparam int HEADER_BYTES = 80;

  // Witness commitment scriptPubKey prefix
  function automatic logic [7:0] commit_prefix(input logic [2:0] k);
    case (k)
      3'd0: commit_prefix = 8'h6A;
      3'd1: commit_prefix = 8'h24;
      3'd2: commit_prefix = 8'hAA;
      3'd3: commit_prefix = 8'h21;
      3'd4: commit_prefix = 8'hA9;
      default: commit_prefix = 8'hED;
    endcase
  endfunction

endpackage

### src/bitcoin_block_stream_parser_top.sv
// Each accepted byte's result is written to the output register in the next cycle.
// Throughput: one byte per cycle while out_stall is low; the whole parse is one
// combinational pass over phase counters, input handshake to output register.
// Reset: synchronous active-low rst_n returns the parser to the header phase
// and empties the output register; the last byte of a block also restarts the parser.
`timescale 1ns / 1ps
module bitcoin_block_stream_parser_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_field_class,
  output logic        out_in_stripped,
  output logic        out_in_full,
  output logic        out_tx_end,
  output logic        out_tx_segwit,
  output logic        out_tx_coinbase,
  output logic        out_commitment_first,
  output logic        out_commitment_byte,
  output logic [3:0]  out_status,
  output logic [33:0] out_block_weight,
  output logic [31:0] out_tx_total
);
  import bbsp_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam logic [63:0] LEN_MAX64 =
    (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);

  typedef enum logic [4:0] {
    P_HDR, P_TXCNT, P_VER, P_MARK, P_FLAG, P_INCNT, P_OUTPT, P_SIGLEN, P_SIG,
    P_SEQ, P_OUTCNT, P_VALUE, P_SPKLEN, P_SPK, P_WITCNT, P_ITEMLEN, P_ITEM,
    P_LOCK, P_DONE, P_ERR
  } phase_t;

  typedef logic [LB-1:0] len_t;

  phase_t      phase_r, phase_nxt;
  len_t        fbl_r, fbl_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cwl_r, cwl_nxt;
  logic [2:0]  pos_r, pos_nxt;
  len_t        tx_left_r, tx_left_nxt;
  len_t        tx_seen_r, tx_seen_nxt;
  len_t        in_tot_r, in_tot_nxt;
  len_t        in_left_r, in_left_nxt;
  len_t        out_left_r, out_left_nxt;
  len_t        wit_left_r, wit_left_nxt;
  len_t        tot_len_r, tot_len_nxt;
  len_t        str_len_r, str_len_nxt;
  logic        txf_segwit_r, txf_segwit_nxt;
  logic        txf_nullop_r, txf_nullop_nxt;
  logic        cbk_commit_r, cbk_commit_nxt;
  logic        cbk_witness_r, cbk_witness_nxt;
  logic        cbk_coinbase_r, cbk_coinbase_nxt;
  logic        cbk_wcount1_r, cbk_wcount1_nxt;
  logic        cbk_wlen32_r, cbk_wlen32_nxt;
  logic [5:0]  cm_r, cm_nxt;
  logic [3:0]  err_r, err_nxt;

  logic        out_valid_r;
  logic [4:0]  cls_r, cls_nxt;
  logic        s_r, s_nxt, f_r, f_nxt, te_r, te_nxt, sw_r, sw_nxt;
  logic        cb_r, cb_nxt, cf_r, cf_nxt, cbyte_r, cbyte_nxt;
  logic [3:0]  st_r, st_nxt;
  logic [33:0] w_r, w_nxt;
  logic [31:0] tt_r, tt_nxt;

  logic in_acc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Parse one byte
  always_comb begin
    logic        done;
    len_t        v;
    logic [5:0]  k;
    logic [66:0] wsum;
    logic [63:0] ts64;
    logic [7:0]  b;
    b = in_byte_value;
    phase_nxt = phase_r; fbl_nxt = fbl_r; acc_nxt = acc_r; cwl_nxt = cwl_r;
    pos_nxt = pos_r; tx_left_nxt = tx_left_r; tx_seen_nxt = tx_seen_r;
    in_tot_nxt = in_tot_r; in_left_nxt = in_left_r; out_left_nxt = out_left_r;
    wit_left_nxt = wit_left_r; tot_len_nxt = tot_len_r; str_len_nxt = str_len_r;
    txf_segwit_nxt = txf_segwit_r; txf_nullop_nxt = txf_nullop_r;
    cbk_commit_nxt = cbk_commit_r; cbk_witness_nxt = cbk_witness_r;
    cbk_coinbase_nxt = cbk_coinbase_r; cbk_wcount1_nxt = cbk_wcount1_r;
    cbk_wlen32_nxt = cbk_wlen32_r; cm_nxt = cm_r; err_nxt = err_r;
    cls_nxt = FC_HEADER; s_nxt = 1'b0; f_nxt = 1'b0; te_nxt = 1'b0; sw_nxt = 1'b0;
    cb_nxt = 1'b0; cf_nxt = 1'b0; cbyte_nxt = 1'b0; st_nxt = ST_BUSY;
    w_nxt = '0; tt_nxt = '0; done = 1'b0; v = '0; k = '0; wsum = '0; ts64 = '0;

    // Zero after version is the marker; anything else starts the input count
    if (phase_nxt == P_MARK && b != 8'd0) phase_nxt = P_INCNT;

    // Label the byte and count lengths
    case (phase_nxt)
      P_HDR:     cls_nxt = FC_HEADER;
      P_TXCNT:   cls_nxt = FC_TXCOUNT;
      P_VER:     cls_nxt = FC_VERSION;
      P_MARK:    cls_nxt = FC_MARKER;
      P_FLAG:    cls_nxt = FC_MARKER;
      P_INCNT:   cls_nxt = FC_INCOUNT;
      P_OUTPT:   cls_nxt = FC_OUTPOINT;
      P_SIGLEN:  cls_nxt = FC_SIGLEN;
      P_SIG:     cls_nxt = FC_SIG;
      P_SEQ:     cls_nxt = FC_SEQUENCE;
      P_OUTCNT:  cls_nxt = FC_OUTCOUNT;
      P_VALUE:   cls_nxt = FC_VALUE;
      P_SPKLEN:  cls_nxt = FC_SPKLEN;
      P_SPK:     cls_nxt = FC_SPK;
      P_WITCNT:  cls_nxt = FC_WITCOUNT;
      P_ITEMLEN: cls_nxt = FC_ITEMLEN;
      P_ITEM:    cls_nxt = FC_ITEM;
      P_LOCK:    cls_nxt = FC_LOCKTIME;
      default:   cls_nxt = FC_HEADER;
    endcase
    if (phase_nxt != P_DONE && phase_nxt != P_ERR) begin
      s_nxt = !(cls_nxt inside {FC_MARKER, FC_WITCOUNT, FC_ITEMLEN, FC_ITEM});
      f_nxt = cls_nxt >= FC_VERSION;
      if (tot_len_nxt != '1) tot_len_nxt = tot_len_nxt + len_t'(1);
      if (s_nxt && str_len_nxt != '1) str_len_nxt = str_len_nxt + len_t'(1);
    end

    case (phase_nxt)
      P_TXCNT, P_INCNT, P_SIGLEN, P_OUTCNT, P_SPKLEN, P_WITCNT, P_ITEMLEN: begin
        // Decode compact size
        if (cwl_nxt == 4'd0) begin
          if (b < 8'd253) begin
            v = len_t'(b);
            done = 1'b1;
          end else begin
            cwl_nxt = (b == 8'd253) ? 4'd2 : (b == 8'd254) ? 4'd4 : 4'd8;
            acc_nxt = '0;
            pos_nxt = '0;
          end
        end else begin
          acc_nxt[{pos_nxt, 3'b000} +: 8] = b;
          pos_nxt = pos_nxt + 3'd1;
          cwl_nxt = cwl_nxt - 4'd1;
          if (cwl_nxt == 4'd0) begin
            v = len_t'((acc_nxt > LEN_MAX64) ? LEN_MAX64 : acc_nxt);
            done = 1'b1;
          end
        end
        if (done) begin
          case (phase_nxt)
            P_TXCNT: begin
              tx_left_nxt = v;
              if (v == '0) phase_nxt = P_DONE;
              else begin
                phase_nxt = P_VER; fbl_nxt = len_t'(4); txf_segwit_nxt = 1'b0;
                txf_nullop_nxt = 1'b0;
              end
            end
            P_INCNT: begin
              if (v == '0) begin
                if (err_nxt == 4'd0) err_nxt = ST_ZERO_INPUTS;
                phase_nxt = P_ERR;
              end else begin
                in_tot_nxt = v; in_left_nxt = v; txf_nullop_nxt = 1'b1;
                phase_nxt = P_OUTPT; fbl_nxt = len_t'(36);
              end
            end
            P_SIGLEN: begin
              if (v == '0) begin phase_nxt = P_SEQ; fbl_nxt = len_t'(4); end
              else begin phase_nxt = P_SIG; fbl_nxt = v; end
            end
            P_OUTCNT: begin
              out_left_nxt = v;
              if (v != '0) begin phase_nxt = P_VALUE; fbl_nxt = len_t'(8); end
              else if (txf_segwit_nxt) begin
                in_left_nxt = in_tot_nxt; phase_nxt = P_WITCNT;
              end else begin phase_nxt = P_LOCK; fbl_nxt = len_t'(4); end
            end
            P_SPKLEN: begin
              cm_nxt = (tx_seen_nxt == '0 && v >= len_t'(38)) ? 6'd1 : 6'd0;
              if (v != '0) begin phase_nxt = P_SPK; fbl_nxt = v; end
              else begin
                out_left_nxt = out_left_nxt - len_t'(1);
                if (out_left_nxt != '0) begin phase_nxt = P_VALUE; fbl_nxt = len_t'(8); end
                else if (txf_segwit_nxt) begin
                  in_left_nxt = in_tot_nxt; phase_nxt = P_WITCNT;
                end else begin phase_nxt = P_LOCK; fbl_nxt = len_t'(4); end
              end
            end
            P_WITCNT: begin
              if (tx_seen_nxt == '0 && in_left_nxt == in_tot_nxt && v == len_t'(1))
                cbk_wcount1_nxt = 1'b1;
              wit_left_nxt = v;
              if (v != '0) phase_nxt = P_ITEMLEN;
              else begin
                in_left_nxt = in_left_nxt - len_t'(1);
                if (in_left_nxt != '0) phase_nxt = P_WITCNT;
                else begin phase_nxt = P_LOCK; fbl_nxt = len_t'(4); end
              end
            end
            default: begin
              if (tx_seen_nxt == '0 && in_left_nxt == in_tot_nxt && cbk_wcount1_nxt &&
                  v == len_t'(32))
                cbk_wlen32_nxt = 1'b1;
              if (v != '0) begin phase_nxt = P_ITEM; fbl_nxt = v; end
              else begin
                wit_left_nxt = wit_left_nxt - len_t'(1);
                if (wit_left_nxt != '0) phase_nxt = P_ITEMLEN;
                else begin
                  in_left_nxt = in_left_nxt - len_t'(1);
                  if (in_left_nxt != '0) phase_nxt = P_WITCNT;
                  else begin phase_nxt = P_LOCK; fbl_nxt = len_t'(4); end
                end
              end
            end
          endcase
        end
      end
      P_MARK: phase_nxt = P_FLAG;
      P_FLAG: begin
        if (b != 8'h01) begin
          if (err_nxt == 4'd0) err_nxt = ST_BAD_FLAG;
          phase_nxt = P_ERR;
        end else begin
          txf_segwit_nxt = 1'b1; cbk_witness_nxt = 1'b1; phase_nxt = P_INCNT;
        end
      end
      P_DONE: begin
        if (err_nxt == 4'd0) err_nxt = ST_TRAILING;
        phase_nxt = P_ERR;
      end
      P_ERR: ;
      default: begin
        // Null outpoint check on the first input
        if (phase_nxt == P_OUTPT && in_left_nxt == in_tot_nxt) begin
          if (b != ((fbl_nxt > len_t'(4)) ? 8'h00 : 8'hFF)) txf_nullop_nxt = 1'b0;
        end
        // Track the witness commitment pattern
        if (phase_nxt == P_SPK && cm_nxt != 6'd0) begin
          k = cm_nxt - 6'd1;
          if (k < 6'd6) begin
            if (b == commit_prefix(k[2:0])) begin
              cm_nxt = cm_nxt + 6'd1;
              if (k == 6'd5) cbk_commit_nxt = 1'b1;
            end else cm_nxt = 6'd0;
          end else begin
            cbyte_nxt = 1'b1;
            cf_nxt = k == 6'd6;
            cm_nxt = (k >= 6'd37) ? 6'd0 : cm_nxt + 6'd1;
          end
        end
        fbl_nxt = fbl_nxt - len_t'(1);
        if (fbl_nxt == '0) begin
          case (phase_nxt)
            P_HDR:   phase_nxt = P_TXCNT;
            P_VER:   phase_nxt = P_MARK;
            P_OUTPT: phase_nxt = P_SIGLEN;
            P_SIG:   begin phase_nxt = P_SEQ; fbl_nxt = len_t'(4); end
            P_SEQ: begin
              in_left_nxt = in_left_nxt - len_t'(1);
              if (in_left_nxt != '0) begin phase_nxt = P_OUTPT; fbl_nxt = len_t'(36); end
              else phase_nxt = P_OUTCNT;
            end
            P_VALUE: phase_nxt = P_SPKLEN;
            P_SPK: begin
              out_left_nxt = out_left_nxt - len_t'(1);
              if (out_left_nxt != '0) begin phase_nxt = P_VALUE; fbl_nxt = len_t'(8); end
              else if (txf_segwit_nxt) begin
                in_left_nxt = in_tot_nxt; phase_nxt = P_WITCNT;
              end else begin phase_nxt = P_LOCK; fbl_nxt = len_t'(4); end
            end
            P_ITEM: begin
              wit_left_nxt = wit_left_nxt - len_t'(1);
              if (wit_left_nxt != '0) phase_nxt = P_ITEMLEN;
              else begin
                in_left_nxt = in_left_nxt - len_t'(1);
                if (in_left_nxt != '0) phase_nxt = P_WITCNT;
                else begin phase_nxt = P_LOCK; fbl_nxt = len_t'(4); end
              end
            end
            default: begin
              // End of transaction
              te_nxt = 1'b1;
              sw_nxt = txf_segwit_nxt;
              cb_nxt = in_tot_nxt == len_t'(1) && txf_nullop_nxt;
              if (tx_seen_nxt == '0 && cb_nxt) cbk_coinbase_nxt = 1'b1;
              if (tx_seen_nxt != '1) tx_seen_nxt = tx_seen_nxt + len_t'(1);
              tx_left_nxt = tx_left_nxt - len_t'(1);
              if (tx_left_nxt != '0) begin
                phase_nxt = P_VER; fbl_nxt = len_t'(4); txf_segwit_nxt = 1'b0;
                txf_nullop_nxt = 1'b0;
              end else phase_nxt = P_DONE;
            end
          endcase
        end
      end
    endcase

    if (!te_nxt && cls_nxt >= FC_VERSION && phase_nxt != P_ERR) sw_nxt = txf_segwit_nxt;
    if (cls_nxt == FC_HEADER && phase_nxt == P_ERR) begin s_nxt = 1'b0; f_nxt = 1'b0; end

    // Verdict on the last byte, then restart
    if (!in_last_byte) begin
      st_nxt = (err_nxt != 4'd0) ? ST_HELD : ST_BUSY;
    end else begin
      if (err_nxt != 4'd0) st_nxt = err_nxt;
      else if (phase_nxt != P_DONE) st_nxt = ST_TRUNCATED;
      else if (tx_seen_nxt == '0) st_nxt = ST_NO_TX;
      else if (cbk_commit_nxt || cbk_witness_nxt) begin
        if (!cbk_coinbase_nxt) st_nxt = ST_NOT_CB;
        else if (!cbk_commit_nxt) st_nxt = ST_NO_COMMIT;
        else if (cbk_witness_nxt && !(cbk_wcount1_nxt && cbk_wlen32_nxt))
          st_nxt = ST_BAD_CB_WIT;
        else st_nxt = ST_OK;
      end else st_nxt = ST_OK;
      if (st_nxt == ST_OK) begin
        wsum = 67'(str_len_nxt) + (67'(str_len_nxt) << 1) + 67'(tot_len_nxt);
        w_nxt = (wsum > 67'(W34_MAX)) ? W34_MAX : wsum[33:0];
        ts64 = 64'(tx_seen_nxt);
        tt_nxt = (ts64 > 64'hFFFFFFFF) ? 32'hFFFFFFFF : ts64[31:0];
      end
      phase_nxt = P_HDR; fbl_nxt = len_t'(HEADER_BYTES); acc_nxt = '0; cwl_nxt = '0;
      pos_nxt = '0; tx_left_nxt = '0; tx_seen_nxt = '0; in_tot_nxt = '0;
      in_left_nxt = '0; out_left_nxt = '0; wit_left_nxt = '0; tot_len_nxt = '0;
      str_len_nxt = '0; txf_segwit_nxt = 1'b0; txf_nullop_nxt = 1'b0;
      cbk_commit_nxt = 1'b0; cbk_witness_nxt = 1'b0; cbk_coinbase_nxt = 1'b0;
      cbk_wcount1_nxt = 1'b0; cbk_wlen32_nxt = 1'b0; cm_nxt = '0; err_nxt = '0;
    end
  end

  // Hold parse state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_HDR; fbl_r <= len_t'(HEADER_BYTES); acc_r <= '0; cwl_r <= '0;
      pos_r <= '0; tx_left_r <= '0; tx_seen_r <= '0; in_tot_r <= '0; in_left_r <= '0;
      out_left_r <= '0; wit_left_r <= '0; tot_len_r <= '0; str_len_r <= '0;
      txf_segwit_r <= 1'b0; txf_nullop_r <= 1'b0; cbk_commit_r <= 1'b0;
      cbk_witness_r <= 1'b0; cbk_coinbase_r <= 1'b0; cbk_wcount1_r <= 1'b0;
      cbk_wlen32_r <= 1'b0; cm_r <= '0; err_r <= '0; out_valid_r <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt; fbl_r <= fbl_nxt; acc_r <= acc_nxt; cwl_r <= cwl_nxt;
      pos_r <= pos_nxt; tx_left_r <= tx_left_nxt; tx_seen_r <= tx_seen_nxt;
      in_tot_r <= in_tot_nxt; in_left_r <= in_left_nxt; out_left_r <= out_left_nxt;
      wit_left_r <= wit_left_nxt; tot_len_r <= tot_len_nxt; str_len_r <= str_len_nxt;
      txf_segwit_r <= txf_segwit_nxt; txf_nullop_r <= txf_nullop_nxt;
      cbk_commit_r <= cbk_commit_nxt; cbk_witness_r <= cbk_witness_nxt;
      cbk_coinbase_r <= cbk_coinbase_nxt; cbk_wcount1_r <= cbk_wcount1_nxt;
      cbk_wlen32_r <= cbk_wlen32_nxt; cm_r <= cm_nxt; err_r <= err_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cls_r <= cls_nxt; s_r <= s_nxt; f_r <= f_nxt; te_r <= te_nxt; sw_r <= sw_nxt;
      cb_r <= cb_nxt; cf_r <= cf_nxt; cbyte_r <= cbyte_nxt; st_r <= st_nxt;
      w_r <= w_nxt; tt_r <= tt_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_field_class      = cls_r;
  assign out_in_stripped      = s_r;
  assign out_in_full          = f_r;
  assign out_tx_end           = te_r;
  assign out_tx_segwit        = sw_r;
  assign out_tx_coinbase      = cb_r;
  assign out_commitment_first = cf_r;
  assign out_commitment_byte  = cbyte_r;
  assign out_status           = st_r;
  assign out_block_weight     = w_r;
  assign out_tx_total         = tt_r;

  a_cb_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_coinbase |-> out_tx_end)
    else $error("coinbase flag outside transaction end");
  a_end_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_end |-> out_field_class == FC_LOCKTIME)
    else $error("transaction end not on locktime byte");
  a_cf_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_commitment_first |-> out_commitment_byte && out_field_class == FC_SPK)
    else $error("commitment start outside commitment bytes");
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_block_weight == '0 && out_tx_total == '0)
    else $error("totals reported without ok status");
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_byte |=> phase_r == P_HDR && err_r == 4'd0)
    else $error("parser not restarted after last byte");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import bbsp_pkg::*;

  localparam int          LIMIT_CYCLES = 400000;
  localparam logic [63:0] LEN_MAX      = 64'hFFFFFFFF;
  localparam logic [63:0] WEIGHT_MAX   = 64'h3FFFFFFFF;

  // Parser phases of the predictor
  localparam logic [4:0] PH_HDR = 5'd0, PH_TXCNT = 5'd1, PH_VER = 5'd2, PH_MARK = 5'd3,
    PH_FLAG = 5'd4, PH_INCNT = 5'd5, PH_OUTPT = 5'd6, PH_SIGLEN = 5'd7, PH_SIG = 5'd8,
    PH_SEQ = 5'd9, PH_OUTCNT = 5'd10, PH_VALUE = 5'd11, PH_SPKLEN = 5'd12, PH_SPK = 5'd13,
    PH_WITCNT = 5'd14, PH_ITEMLEN = 5'd15, PH_ITEM = 5'd16, PH_LOCK = 5'd17,
    PH_DONE = 5'd18, PH_ERR = 5'd19;

  // Block shapes for the generator
  localparam int BK_LEGACY = 0, BK_SEGWIT = 1, BK_TRUNC = 2, BK_BADFLAG = 3, BK_ZEROIN = 4,
    BK_TRAIL = 5, BK_NOTX = 6, BK_NOTCB = 7, BK_NOCOMMIT = 8, BK_BADWIT = 9, BK_HUGE = 10,
    BK_COUNT = 11;

  typedef struct packed {
    logic [4:0]  cls;
    logic        strip;
    logic        full;
    logic        tx_end;
    logic        segwit;
    logic        coinbase;
    logic        cfirst;
    logic        cbyte;
    logic [3:0]  status;
    logic [33:0] weight;
    logic [31:0] txs;
  } parse_res_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } raw_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte_value;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_field_class;
  logic        out_in_stripped;
  logic        out_in_full;
  logic        out_tx_end;
  logic        out_tx_segwit;
  logic        out_tx_coinbase;
  logic        out_commitment_first;
  logic        out_commitment_byte;
  logic [3:0]  out_status;
  logic [33:0] out_block_weight;
  logic [31:0] out_tx_total;

  bitcoin_block_stream_parser_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_byte_value        (in_byte_value),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_field_class      (out_field_class),
    .out_in_stripped      (out_in_stripped),
    .out_in_full          (out_in_full),
    .out_tx_end           (out_tx_end),
    .out_tx_segwit        (out_tx_segwit),
    .out_tx_coinbase      (out_tx_coinbase),
    .out_commitment_first (out_commitment_first),
    .out_commitment_byte  (out_commitment_byte),
    .out_status           (out_status),
    .out_block_weight     (out_block_weight),
    .out_tx_total         (out_tx_total)
  );

  raw_byte_t  byte_q[$];
  parse_res_t label_q[$];
  logic [7:0] blk[$];
  int         errors;
  int         cycles;
  int         in_gap;
  int         out_gap;
  logic       burst;
  logic       took;

  // Parser state mirror
  logic [4:0]  ph;
  logic [63:0] fleft, cacc, tx_left, seen, in_tot, in_left, out_left, wit_left, tot_len, strp_len;
  int          cwidth, cshift, cmatch;
  logic        tx_sw, tx_null;
  logic        cb_commit, cb_wit, cb_coin, cb_w1, cb_w32;
  logic [3:0]  err_held;
  logic [7:0]  cpfx[6] = '{8'h6A, 8'h24, 8'hAA, 8'h21, 8'hA9, 8'hED};

  function automatic void parser_clear();
    ph = PH_HDR; fleft = 80; cacc = 0; cwidth = 0; cshift = 0;
    tx_left = 0; seen = 0; in_tot = 0; in_left = 0; out_left = 0; wit_left = 0;
    tot_len = 0; strp_len = 0; tx_sw = 0; tx_null = 0;
    cb_commit = 0; cb_wit = 0; cb_coin = 0; cb_w1 = 0; cb_w32 = 0;
    cmatch = 0; err_held = 0;
  endfunction

  function automatic logic [63:0] sat_inc(input logic [63:0] x);
    return (x < LEN_MAX) ? x + 1 : x;
  endfunction

  function automatic void raise(input logic [3:0] code);
    if (err_held == 0) err_held = code;
    ph = PH_ERR;
  endfunction

  function automatic void go_fixed(input logic [4:0] p, input logic [63:0] n);
    ph = p; fleft = n;
  endfunction

  function automatic void start_tx();
    go_fixed(PH_VER, 4); tx_sw = 0; tx_null = 0;
  endfunction

  function automatic void after_outputs();
    if (tx_sw) begin
      in_left = in_tot; ph = PH_WITCNT;
    end else go_fixed(PH_LOCK, 4);
  endfunction

  function automatic void next_output();
    out_left--;
    if (out_left != 0) go_fixed(PH_VALUE, 8); else after_outputs();
  endfunction

  function automatic void next_wit_input();
    in_left--;
    if (in_left != 0) ph = PH_WITCNT; else go_fixed(PH_LOCK, 4);
  endfunction

  function automatic void next_item();
    wit_left--;
    if (wit_left != 0) ph = PH_ITEMLEN; else next_wit_input();
  endfunction

  // Accumulate a compact size; return 1 once the value is complete
  function automatic logic compact_step(input logic [7:0] b, output logic [63:0] v);
    v = 0;
    if (cwidth == 0) begin
      if (b < 253) begin
        v = b; return 1;
      end
      cwidth = (b == 8'hFD) ? 2 : (b == 8'hFE) ? 4 : 8;
      cacc = 0; cshift = 0;
      return 0;
    end
    cacc |= 64'(b) << cshift;
    cshift += 8;
    cwidth--;
    if (cwidth != 0) return 0;
    v = (cacc > LEN_MAX) ? LEN_MAX : cacc;
    return 1;
  endfunction

  function automatic void compact_done(input logic [63:0] v);
    logic first_in;
    first_in = (seen == 0) && (in_left == in_tot);
    case (ph)
      PH_TXCNT: begin
        tx_left = v;
        if (v == 0) ph = PH_DONE; else start_tx();
      end
      PH_INCNT: begin
        if (v == 0) raise(ST_ZERO_INPUTS);
        else begin
          in_tot = v; in_left = v; tx_null = 1;
          go_fixed(PH_OUTPT, 36);
        end
      end
      PH_SIGLEN: if (v == 0) go_fixed(PH_SEQ, 4); else go_fixed(PH_SIG, v);
      PH_OUTCNT: begin
        out_left = v;
        if (v == 0) after_outputs(); else go_fixed(PH_VALUE, 8);
      end
      PH_SPKLEN: begin
        cmatch = (seen == 0 && v >= 38) ? 1 : 0;
        if (v == 0) next_output(); else go_fixed(PH_SPK, v);
      end
      PH_WITCNT: begin
        if (first_in && v == 1) cb_w1 = 1;
        wit_left = v;
        if (v == 0) next_wit_input(); else ph = PH_ITEMLEN;
      end
      default: begin
        if (first_in && cb_w1 && v == 32) cb_w32 = 1;
        if (v == 0) next_item(); else go_fixed(PH_ITEM, v);
      end
    endcase
  endfunction

  // Label one byte and advance the parser mirror
  function automatic parse_res_t label_byte(input logic [7:0] b, input logic last);
    parse_res_t r;
    logic [63:0] v, idx, w;
    int k;
    r = '0;
    if (ph == PH_MARK && b != 0) ph = PH_INCNT;
    if (ph < PH_DONE) begin
      r.cls = (ph <= PH_MARK) ? ph : ph - 5'd1;
      r.strip = r.cls <= FC_VERSION || (r.cls >= FC_INCOUNT && r.cls <= FC_SPK) ||
                r.cls == FC_LOCKTIME;
      r.full = r.cls >= FC_VERSION;
      tot_len = sat_inc(tot_len);
      if (r.strip) strp_len = sat_inc(strp_len);
    end
    case (ph)
      PH_TXCNT, PH_INCNT, PH_SIGLEN, PH_OUTCNT, PH_SPKLEN, PH_WITCNT, PH_ITEMLEN:
        if (compact_step(b, v)) compact_done(v);
      PH_MARK: ph = PH_FLAG;
      PH_FLAG: begin
        if (b != 8'h01) raise(ST_BAD_FLAG);
        else begin
          tx_sw = 1; cb_wit = 1; ph = PH_INCNT;
        end
      end
      PH_DONE: raise(ST_TRAILING);
      PH_ERR: ;
      default: begin
        // null outpoint is 32 zero bytes then four 0xFF
        if (ph == PH_OUTPT && in_left == in_tot) begin
          idx = 36 - fleft;
          if (b != ((idx < 32) ? 8'h00 : 8'hFF)) tx_null = 0;
        end
        // track the commitment prefix, then flag the 32 hash bytes
        if (ph == PH_SPK && cmatch != 0) begin
          k = cmatch - 1;
          if (k < 6) begin
            if (b == cpfx[k]) begin
              cmatch++;
              if (k == 5) cb_commit = 1;
            end else cmatch = 0;
          end else begin
            r.cbyte = 1;
            r.cfirst = (k == 6);
            cmatch = (k >= 37) ? 0 : cmatch + 1;
          end
        end
        fleft--;
        if (fleft == 0) begin
          case (ph)
            PH_HDR: ph = PH_TXCNT;
            PH_VER: ph = PH_MARK;
            PH_OUTPT: ph = PH_SIGLEN;
            PH_SIG: go_fixed(PH_SEQ, 4);
            PH_SEQ: begin
              in_left--;
              if (in_left != 0) go_fixed(PH_OUTPT, 36); else ph = PH_OUTCNT;
            end
            PH_VALUE: ph = PH_SPKLEN;
            PH_SPK: next_output();
            PH_ITEM: next_item();
            default: begin
              r.tx_end = 1;
              r.segwit = tx_sw;
              r.coinbase = (in_tot == 1) && tx_null;
              if (seen == 0 && r.coinbase) cb_coin = 1;
              seen = sat_inc(seen);
              tx_left--;
              if (tx_left != 0) start_tx(); else ph = PH_DONE;
            end
          endcase
        end
      end
    endcase
    if (!r.tx_end && r.cls >= FC_VERSION && ph != PH_ERR) r.segwit = tx_sw;
    if (r.cls == FC_HEADER && ph == PH_ERR) begin
      r.strip = 0; r.full = 0;
    end
    // verdict on the final byte, then start over
    if (!last) r.status = (err_held != 0) ? ST_HELD : ST_BUSY;
    else begin
      if (err_held != 0) r.status = err_held;
      else if (ph != PH_DONE) r.status = ST_TRUNCATED;
      else if (seen == 0) r.status = ST_NO_TX;
      else if (cb_commit || cb_wit) begin
        if (!cb_coin) r.status = ST_NOT_CB;
        else if (!cb_commit) r.status = ST_NO_COMMIT;
        else if (cb_wit && !(cb_w1 && cb_w32)) r.status = ST_BAD_CB_WIT;
        else r.status = ST_OK;
      end else r.status = ST_OK;
      if (r.status == ST_OK) begin
        if (strp_len > WEIGHT_MAX / 3) w = WEIGHT_MAX;
        else begin
          w = 3 * strp_len;
          w = (tot_len > WEIGHT_MAX - w) ? WEIGHT_MAX : w + tot_len;
        end
        r.weight = w[33:0];
        r.txs = (seen > 64'hFFFFFFFF) ? 32'hFFFFFFFF : seen[31:0];
      end
      parser_clear();
    end
    return r;
  endfunction

  // Block builder
  function automatic void put_rand(input int n);
    for (int i = 0; i < n; i++) blk.push_back(8'($urandom));
  endfunction

  // Emit a compact size, sometimes in a wider encoding than needed
  function automatic void put_compact(input logic [63:0] v);
    int pick;
    pick = $urandom_range(0, 9);
    if (v < 253 && pick < 7) blk.push_back(v[7:0]);
    else if (v < 65536 && pick < 8) begin
      blk.push_back(8'hFD); blk.push_back(v[7:0]); blk.push_back(v[15:8]);
    end else if (v < 64'h100000000 && pick < 9) begin
      blk.push_back(8'hFE);
      for (int i = 0; i < 4; i++) blk.push_back(v[8*i +: 8]);
    end else begin
      blk.push_back(8'hFF);
      for (int i = 0; i < 8; i++) blk.push_back(v[8*i +: 8]);
    end
  endfunction

  function automatic void put_spk(input logic commit);
    int n, brk;
    if (commit || $urandom_range(0, 5) == 0) begin
      n = $urandom_range(38, 41);
      brk = commit ? 6 : $urandom_range(0, 6);
      put_compact(n);
      for (int i = 0; i < 6; i++) blk.push_back(i == brk ? ~cpfx[i] : cpfx[i]);
      put_rand(n - 6);
    end else begin
      n = $urandom_range(0, 6);
      put_compact(n);
      put_rand(n);
    end
  endfunction

  function automatic void put_tx(input logic cb, input logic sw, input logic commit,
                                 input logic badwit, input logic zero_in,
                                 input logic [7:0] flag);
    int ni, no, nw, n;
    put_rand(4);
    if (sw) begin
      blk.push_back(8'h00); blk.push_back(flag);
    end
    ni = zero_in ? 0 : cb ? 1 : $urandom_range(1, 3);
    put_compact(ni);
    for (int i = 0; i < ni; i++) begin
      if (cb || (ni == 1 && $urandom_range(0, 7) == 0)) begin
        for (int j = 0; j < 32; j++) blk.push_back(8'h00);
        for (int j = 0; j < 4; j++) blk.push_back(8'hFF);
      end else put_rand(36);
      n = $urandom_range(0, 5);
      put_compact(n); put_rand(n); put_rand(4);
    end
    no = cb ? $urandom_range(0, 2) : $urandom_range(0, 3);
    put_compact(no + (commit ? 1 : 0));
    for (int i = 0; i < no + (commit ? 1 : 0); i++) begin
      put_rand(8);
      put_spk(commit && i == no);
    end
    if (sw) begin
      for (int i = 0; i < ni; i++) begin
        if (cb) begin
          nw = (badwit && $urandom_range(0, 1)) ? 2 : 1;
          put_compact(nw);
          for (int j = 0; j < nw; j++) begin
            n = (badwit && nw == 1) ? 31 : 32;
            put_compact(n); put_rand(n);
          end
        end else begin
          nw = $urandom_range(0, 2);
          put_compact(nw);
          for (int j = 0; j < nw; j++) begin
            n = $urandom_range(0, 4);
            put_compact(n); put_rand(n);
          end
        end
      end
    end
    put_rand(4);
  endfunction

  task automatic queue_block(input int kind);
    int ntx, cut;
    logic [7:0] fl;
    raw_byte_t rb;
    blk.delete();
    put_rand(80);
    if (kind == BK_HUGE) begin
      // large script length that may saturate, then the block stops short
      put_compact(1); put_rand(4); blk.push_back(8'h01); put_rand(36);
      if ($urandom_range(0, 1)) begin
        blk.push_back(8'hFF);
        for (int i = 0; i < 8; i++) blk.push_back(8'hFF);
      end else begin
        blk.push_back(8'hFE); put_rand(4);
      end
      put_rand($urandom_range(0, 4));
    end else if (kind == BK_NOTX) begin
      put_compact(0);
    end else begin
      ntx = $urandom_range(1, 2);
      put_compact(ntx);
      fl = 8'h01;
      if (kind == BK_BADFLAG) begin
        do fl = 8'($urandom); while (fl == 8'h01);
      end
      for (int t = 0; t < ntx; t++) begin
        if (t == 0) begin
          case (kind)
            BK_LEGACY: put_tx(1, 0, 0, 0, 0, 8'h01);
            BK_NOTCB: put_tx(0, 1, 0, 0, 0, 8'h01);
            BK_NOCOMMIT: put_tx(1, 1, 0, 0, 0, 8'h01);
            BK_BADWIT: put_tx(1, 1, 1, 1, 0, 8'h01);
            BK_ZEROIN: put_tx(0, 1, 0, 0, 1, 8'h01);
            BK_BADFLAG: put_tx(1, 1, 1, 0, 0, fl);
            default: put_tx(1, 1, 1, 0, 0, 8'h01);
          endcase
        end else begin
          put_tx(0, kind != BK_LEGACY && $urandom_range(0, 1), 0, 0, 0, 8'h01);
        end
      end
    end
    if (kind == BK_TRUNC) begin
      cut = $urandom_range(1, blk.size() - 1);
      repeat (cut) void'(blk.pop_back());
    end
    if (kind == BK_TRAIL) put_rand($urandom_range(1, 3));
    foreach (blk[i]) begin
      rb.value = blk[i];
      rb.last = (i == blk.size() - 1);
      byte_q.push_back(rb);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Stimulus: directed blocks of every shape, then a random mix of well-formed and malformed blocks
  initial begin
    raw_byte_t rb;
    int total;
    errors = 0;
    parser_clear();
    rb.value = 8'hFF; rb.last = 1'b1;
    byte_q.push_back(rb);
    for (int k = 0; k < BK_COUNT; k++) queue_block(k);
    total = byte_q.size();
    while (total < 1250) begin
      total -= byte_q.size();
      case ($urandom_range(0, 9))
        0, 1, 2: queue_block(BK_SEGWIT);
        3, 4: queue_block(BK_LEGACY);
        default: queue_block($urandom_range(BK_TRUNC, BK_HUGE));
      endcase
      total += byte_q.size();
    end
    wait (byte_q.size() == 0 && !in_valid && label_q.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Drive the input channel and the result stall
  always @(negedge clk) begin
    raw_byte_t rb;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte_value <= 8'h00;
      in_last_byte <= 1'b0;
      out_stall <= 1'b0;
      in_gap = 0;
      out_gap = 0;
      burst = 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) burst = ~burst;
      if (!in_valid || took) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          rb = byte_q.pop_front();
          in_valid <= 1'b1;
          in_byte_value <= rb.value;
          in_last_byte <= rb.last;
          in_gap = pick_gap();
        end else in_valid <= 1'b0;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Check each result transaction against the oldest label, record accepted bytes
  always @(posedge clk) begin
    parse_res_t want, got;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_field_class, out_in_stripped, out_in_full, out_tx_end, out_tx_segwit,
                out_tx_coinbase, out_commitment_first, out_commitment_byte, out_status,
                out_block_weight, out_tx_total};
        if (label_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = label_q.pop_front();
          if (got.cls != want.cls)
            $display("%0t: field_class exp %0d got %0d", $time, want.cls, got.cls);
          if (got.strip != want.strip)
            $display("%0t: in_stripped exp %0b got %0b", $time, want.strip, got.strip);
          if (got.full != want.full)
            $display("%0t: in_full exp %0b got %0b", $time, want.full, got.full);
          if (got.tx_end != want.tx_end)
            $display("%0t: tx_end exp %0b got %0b", $time, want.tx_end, got.tx_end);
          if (got.segwit != want.segwit)
            $display("%0t: tx_segwit exp %0b got %0b", $time, want.segwit, got.segwit);
          if (got.coinbase != want.coinbase)
            $display("%0t: tx_coinbase exp %0b got %0b", $time, want.coinbase, got.coinbase);
          if (got.cfirst != want.cfirst)
            $display("%0t: commitment_first exp %0b got %0b", $time, want.cfirst, got.cfirst);
          if (got.cbyte != want.cbyte)
            $display("%0t: commitment_byte exp %0b got %0b", $time, want.cbyte, got.cbyte);
          if (got.status != want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got.weight != want.weight)
            $display("%0t: block_weight exp %0d got %0d", $time, want.weight, got.weight);
          if (got.txs != want.txs)
            $display("%0t: tx_total exp %0d got %0d", $time, want.txs, got.txs);
          if (got !== want) errors++;
        end
      end
      took = in_valid && !in_stall;
      if (took) label_q.push_back(label_byte(in_byte_value, in_last_byte));
    end else took = 1'b0;
  end

  initial cycles = 0;

endmodule
